// ===== hw/rtl/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// Beat payload structs, result codes, register indexes and decode helpers.
// No dependencies.
package u8u16_pkg;

  // Input beat: one source byte and its end-of-string mark
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // Result beat: a code unit or the final status of the string
  typedef struct packed {
    logic        kind;
    logic [15:0] code_unit;
    logic [15:0] unit_index;
    logic [1:0]  status;
    logic [15:0] unit_total;
    logic        out_last;
  } out_t;

  // Per-string decode state, less the unit counter
  typedef struct packed {
    logic [7:0]  lead;
    logic [1:0]  need;
    logic [1:0]  got;
    logic [20:0] payload;
    logic        inv;
    logic        ovf;
  } dec_state_t;

  // Outcome of taking a byte as a lead byte
  typedef struct packed {
    logic        unit_v;
    logic [15:0] unit;
    logic        inv;
    logic        open;
    logic [1:0]  need;
    logic [20:0] payload;
  } lead_t;

  localparam logic KIND_UNIT  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SMALL  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_REJECT   = 1'b1;

  localparam logic [15:0] REPL_CHAR   = 16'hFFFD;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;  // 0xDC00 >> 10
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  localparam logic [7:0] LEAD_MIN   = 8'hC2;
  localparam logic [7:0] LEAD_MAX   = 8'hF4;
  localparam logic [7:0] LEAD_3B    = 8'hE0;
  localparam logic [7:0] LEAD_4B    = 8'hF0;
  localparam logic [7:0] LEAD_SURR  = 8'hED;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] E0_LO      = 8'hA0;
  localparam logic [7:0] ED_HI      = 8'h9F;
  localparam logic [7:0] F0_LO      = 8'h90;
  localparam logic [7:0] F4_HI      = 8'h8F;

  // Classify a byte taken as the start of a new sequence
  function automatic lead_t take_lead(input logic [7:0] b);
    lead_t r;
    r = '0;
    if (b < CONT_LO) begin
      r.unit_v = 1'b1;
      r.unit   = {8'h00, b};
    end else if (b < LEAD_MIN || b > LEAD_MAX) begin
      r.unit_v = 1'b1;
      r.unit   = REPL_CHAR;
      r.inv    = 1'b1;
    end else if (b < LEAD_3B) begin
      r.open    = 1'b1;
      r.need    = 2'd1;
      r.payload = {16'h0000, b[4:0]};
    end else if (b < LEAD_4B) begin
      r.open    = 1'b1;
      r.need    = 2'd2;
      r.payload = {17'h00000, b[3:0]};
    end else begin
      r.open    = 1'b1;
      r.need    = 2'd3;
      r.payload = {18'h00000, b[2:0]};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/u8u16_step.sv =====
// Per-byte decode step: next state and up to three result beats for one byte.
// Pure combinational logic; depends on u8u16_pkg.
module u8u16_step #(
  parameter int MAX_LEN = 65535,
  parameter int CNT_W   = 16
) (
  input  logic [15:0]            capacity,
  input  logic                   reject_invalid,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  input  u8u16_pkg::dec_state_t  state_i,
  input  logic [CNT_W-1:0]       cnt_i,
  output u8u16_pkg::dec_state_t  state_o,
  output logic [CNT_W-1:0]       cnt_o,
  output u8u16_pkg::out_t [2:0]  res_o,
  output logic [2:0]             res_v_o
);

  u8u16_pkg::dec_state_t nx;
  u8u16_pkg::lead_t      ld;
  logic                  r0_v, r1_v;
  logic [15:0]           r0, r1;
  logic [7:0]            lo, hi;
  logic                  is_cont;
  logic [20:0]           acc;
  logic [2:0]            got_inc;
  logic [20:0]           off;
  logic [CNT_W-1:0]      limit, cnt;
  logic                  ovf;
  logic [15:0]           idx0, idx1;
  logic                  u0_v, u1_v;

  // Gather the code units this byte asks for, in order
  always_comb begin
    nx      = state_i;
    r0_v    = 1'b0;
    r1_v    = 1'b0;
    r0      = '0;
    r1      = '0;
    lo      = u8u16_pkg::CONT_LO;
    hi      = u8u16_pkg::CONT_HI;
    is_cont = (byte_i[7:6] == 2'b10);
    acc     = {state_i.payload[14:0], byte_i[5:0]};
    got_inc = {1'b0, state_i.got} + 3'd1;
    off     = acc - u8u16_pkg::SUPP_BASE;
    ld      = u8u16_pkg::take_lead(byte_i);

    if (state_i.lead == u8u16_pkg::LEAD_3B)        lo = u8u16_pkg::E0_LO;
    else if (state_i.lead == u8u16_pkg::LEAD_SURR) hi = u8u16_pkg::ED_HI;
    else if (state_i.lead == u8u16_pkg::LEAD_4B)   lo = u8u16_pkg::F0_LO;
    else if (state_i.lead == u8u16_pkg::LEAD_MAX)  hi = u8u16_pkg::F4_HI;

    if (!state_i.ovf) begin
      if (state_i.need != 2'd0) begin
        if (!is_cont) begin
          // Close the broken sequence, then take the byte again as a lead
          nx.inv  = 1'b1;
          r0_v    = 1'b1;
          r0      = u8u16_pkg::REPL_CHAR;
          r1_v    = ld.unit_v;
          r1      = ld.unit;
          nx.inv  = 1'b1;
          nx.lead = ld.open ? byte_i : 8'h00;
          nx.need = ld.need;
          nx.got  = 2'd0;
          nx.payload = ld.payload;
        end else if (state_i.got == 2'd0 && (byte_i < lo || byte_i > hi)) begin
          // Out-of-range second byte is consumed by the substitution
          nx.inv     = 1'b1;
          nx.lead    = 8'h00;
          nx.need    = 2'd0;
          nx.got     = 2'd0;
          nx.payload = '0;
          r0_v       = 1'b1;
          r0         = u8u16_pkg::REPL_CHAR;
        end else if (got_inc >= {1'b0, state_i.need}) begin
          // Sequence complete: one unit or a surrogate pair
          nx.lead    = 8'h00;
          nx.need    = 2'd0;
          nx.got     = 2'd0;
          nx.payload = '0;
          r0_v       = 1'b1;
          if (acc > 21'h00FFFF) begin
            r0   = {u8u16_pkg::HI_SURR_TAG, off[19:10]};
            r1_v = 1'b1;
            r1   = {u8u16_pkg::LO_SURR_TAG, off[9:0]};
          end else begin
            r0 = acc[15:0];
          end
        end else begin
          nx.payload = acc;
          nx.got     = got_inc[1:0];
        end
      end else begin
        r0_v       = ld.unit_v;
        r0         = ld.unit;
        nx.inv     = state_i.inv | ld.inv;
        nx.lead    = ld.open ? byte_i : 8'h00;
        nx.need    = ld.need;
        nx.got     = 2'd0;
        nx.payload = ld.payload;
      end

      // Truncated tail at the end of the string
      if (last_i && nx.need != 2'd0) begin
        nx.inv = 1'b1;
        if (r0_v) begin
          r1_v = 1'b1;
          r1   = u8u16_pkg::REPL_CHAR;
        end else begin
          r0_v = 1'b1;
          r0   = u8u16_pkg::REPL_CHAR;
        end
      end
    end
  end

  // Check room for each unit in turn
  always_comb begin
    limit = (capacity != 16'd0) ? CNT_W'(capacity) : CNT_W'(MAX_LEN);
    cnt   = cnt_i;
    ovf   = state_i.ovf;
    u0_v  = 1'b0;
    u1_v  = 1'b0;
    idx0  = '0;
    idx1  = '0;
    if (r0_v && !ovf) begin
      if (cnt >= limit) begin
        ovf = 1'b1;
      end else begin
        u0_v = (capacity != 16'd0);
        idx0 = cnt[15:0];
        cnt  = cnt + CNT_W'(1);
      end
    end
    if (r1_v && !ovf) begin
      if (cnt >= limit) begin
        ovf = 1'b1;
      end else begin
        u1_v = (capacity != 16'd0);
        idx1 = cnt[15:0];
        cnt  = cnt + CNT_W'(1);
      end
    end
  end

  // Build result beats and the state left for the next byte
  always_comb begin
    res_o   = '0;
    res_v_o = {last_i, u1_v, u0_v};

    res_o[0].kind       = u8u16_pkg::KIND_UNIT;
    res_o[0].code_unit  = r0;
    res_o[0].unit_index = idx0;
    res_o[1].kind       = u8u16_pkg::KIND_UNIT;
    res_o[1].code_unit  = r1;
    res_o[1].unit_index = idx1;

    res_o[2].kind     = u8u16_pkg::KIND_FINAL;
    res_o[2].out_last = 1'b1;
    if (ovf) begin
      res_o[2].status = u8u16_pkg::ST_SMALL;
    end else if (nx.inv && reject_invalid) begin
      res_o[2].status = u8u16_pkg::ST_REJECT;
    end else begin
      res_o[2].status     = u8u16_pkg::ST_OK;
      res_o[2].unit_total = cnt[15:0];
    end

    if (last_i) begin
      state_o = '0;
      cnt_o   = '0;
    end else begin
      state_o     = nx;
      state_o.ovf = ovf;
      cnt_o       = cnt;
    end
  end

endmodule

// ===== hw/rtl/utf8_to_utf16_decoder_unit.sv =====
// UTF-8 to UTF-16 decoder, top level. Depends on u8u16_pkg and u8u16_step.
// An accepted byte passes the input register, then the result register.
// One byte per cycle while results drain; a byte with k result beats (k up
// to 3) holds the result register, one beat per cycle while out_ready is high.
// Reset: synchronous, active low; clears decode state, valids and config regs.
module utf8_to_utf16_decoder_unit #(
  parameter int MAX_LEN = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  u8u16_pkg::in_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output u8u16_pkg::out_t    out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int LIM   = (MAX_LEN > 65535) ? MAX_LEN : 65535;
  localparam int CNT_W = $clog2(LIM + 1);

  logic [15:0]           capacity_r;
  logic                  reject_r;
  logic                  s0_v_r;
  u8u16_pkg::in_t        s0_r;
  u8u16_pkg::dec_state_t st_r, st_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  u8u16_pkg::out_t [2:0] grp_r, grp_nxt;
  logic [2:0]            grp_v_r, grp_v_nxt, grp_left;
  logic                  out_fire, grp_free, adv;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
      reject_r   <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        u8u16_pkg::REG_CAPACITY: capacity_r <= pwdata[15:0];
        u8u16_pkg::REG_REJECT:   reject_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      u8u16_pkg::REG_CAPACITY: prdata = {16'h0000, capacity_r};
      u8u16_pkg::REG_REJECT:   prdata = {31'h0, reject_r};
      default:                 prdata = '0;
    endcase
  end

  // Drain the result group one beat at a time, lowest slot first
  assign out_valid = |grp_v_r;
  assign out_fire  = out_valid && out_ready;
  assign grp_left  = out_fire ? (grp_v_r & (grp_v_r - 3'd1)) : grp_v_r;
  assign grp_free  = (grp_left == 3'd0);
  assign adv       = s0_v_r && grp_free;
  assign in_ready  = !s0_v_r || adv;

  always_comb begin
    if (grp_v_r[0])      out_data = grp_r[0];
    else if (grp_v_r[1]) out_data = grp_r[1];
    else                 out_data = grp_r[2];
  end

  u8u16_step #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W)
  ) u_step (
    .capacity       (capacity_r),
    .reject_invalid (reject_r),
    .byte_i         (s0_r.in_byte),
    .last_i         (s0_r.in_last),
    .state_i        (st_r),
    .cnt_i          (cnt_r),
    .state_o        (st_nxt),
    .cnt_o          (cnt_nxt),
    .res_o          (grp_nxt),
    .res_v_o        (grp_v_nxt)
  );

  // Input register: hold the beat until the step can take it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_ready) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_r <= in_data;
    end
  end

  // Decode state and result group advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      cnt_r   <= '0;
      grp_v_r <= '0;
    end else if (adv) begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      grp_v_r <= grp_v_nxt;
    end else begin
      grp_v_r <= grp_left;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp_r <= grp_nxt;
    end
  end

endmodule
